/* src/sgcg_pkg.sv */
// shared constants, types and helpers for the strided grid corner unit
// no dependencies
package sgcg_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int DIMS            = 3;
  localparam int NCORNERS        = 1 << DIMS;
  localparam int IDX_BITS        = 12;
  localparam int STRIDE_BITS     = 12;
  localparam int FIELD_BITS      = 32;
  localparam int CFG_IDX_BITS    = 2;
  // widest base plus corner offset: three 24-bit products plus three strides
  localparam int ADDR_SUM_BITS   = 27;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_GATHER  = 2'd2,
    OP_SCATTER = 2'd3
  } op_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE0 = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE1 = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE2 = 2'd2;

  typedef struct packed {
    logic [1:0]                  op;
    logic [IDX_BITS-1:0]         index_0;
    logic [IDX_BITS-1:0]         index_1;
    logic [IDX_BITS-1:0]         index_2;
    logic [NCORNERS*FIELD_BITS-1:0] corner_in;
  } req_t;

  typedef struct packed {
    logic [NCORNERS*FIELD_BITS-1:0] corner_out;
    logic                           addr_error;
  } rsp_t;

endpackage

/* src/sgcg_if.sv */
// valid/ready channel carrying one payload
// payload type given by parameter
interface sgcg_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/sgcg_ram.sv */
// generic single-port synchronous ram, registered read
// no dependencies
module sgcg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* src/sgcg_addr.sv */
// address generator: base from indices and strides, corner offsets, range check
// depends on sgcg_pkg; the products, then the corner addresses and error flag, are registered
module sgcg_addr #(
  parameter int STORE_DEPTH = sgcg_pkg::STORE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               start,
  input  logic [sgcg_pkg::IDX_BITS-1:0]      index_0,
  input  logic [sgcg_pkg::IDX_BITS-1:0]      index_1,
  input  logic [sgcg_pkg::IDX_BITS-1:0]      index_2,
  input  logic [sgcg_pkg::STRIDE_BITS-1:0]   stride_0,
  input  logic [sgcg_pkg::STRIDE_BITS-1:0]   stride_1,
  input  logic [sgcg_pkg::STRIDE_BITS-1:0]   stride_2,
  input  logic                               all_corners,
  output logic [sgcg_pkg::NCORNERS-1:0][$clog2(STORE_DEPTH)-1:0] addr,
  output logic                               err
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SB = sgcg_pkg::ADDR_SUM_BITS;
  logic [2*sgcg_pkg::IDX_BITS-1:0] prod0, prod1, prod2;
  logic [SB-1:0] base;
  logic [SB-1:0] full [sgcg_pkg::NCORNERS];
  logic [sgcg_pkg::NCORNERS-1:0] bad;
  logic          all_q;

  always_ff @(posedge clk) begin
    if (start) begin
      prod0 <= index_0 * stride_0;
      prod1 <= index_1 * stride_1;
      prod2 <= index_2 * stride_2;
      all_q <= all_corners;
    end
  end

  always_comb begin
    base = SB'(prod0) + SB'(prod1) + SB'(prod2);
    for (int k = 0; k < sgcg_pkg::NCORNERS; k++) begin
      full[k] = base + (k[0] ? SB'(stride_0) : '0) + (k[1] ? SB'(stride_1) : '0)
              + (k[2] ? SB'(stride_2) : '0);
      bad[k]  = full[k] >= SB'(STORE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < sgcg_pkg::NCORNERS; k++) addr[k] <= full[k][AW-1:0];
    err <= all_q ? (|bad) : bad[0];
  end
endmodule

/* src/strided_grid_corner_gather_scatter_unit.sv */
// top level: strided 3d grid with cell read/write, corner gather and scatter-add
// depends on sgcg_pkg, sgcg_if, sgcg_ram, sgcg_addr
// a request is taken in S_IDLE; addresses and the range check are registered through S_A1
//   into S_A2, where a write lands; a read or gather reads in S_RD and S_MOD, answers in S_OUT
// one request at a time, also held by output stalls; a range error answers from S_OUT;
//   scatter-add reads then writes back each corner on the one port
// reset: strides go to 1/16/256, then a clearing pass zeroes
// the store; no request is taken until it ends
module strided_grid_corner_gather_scatter_unit #(
  parameter int STORE_DEPTH = sgcg_pkg::STORE_DEPTH_DEF,
  parameter int VALUE_BITS  = sgcg_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic                                 cfg_we,
  input  logic [sgcg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [sgcg_pkg::STRIDE_BITS-1:0]     cfg_data,
  sgcg_if.sink   req,
  sgcg_if.source rsp
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int NC = sgcg_pkg::NCORNERS;
  localparam int FB = sgcg_pkg::FIELD_BITS;
  localparam int CB = $clog2(NC);
  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_A1    = 7'b0000100,
    S_A2    = 7'b0001000,
    S_RD    = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [sgcg_pkg::STRIDE_BITS-1:0] stride_0, stride_1, stride_2;
  logic [AW:0] clr_cnt;
  logic [CB:0] k;
  sgcg_pkg::req_t cur;
  logic [NC-1:0][AW-1:0] caddr;
  logic aerr;
  logic [NC-1:0][FB-1:0] outv;
  logic oerr;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

  // last written cell, forwarded when the next corner hits it
  logic                  fwd_v;
  logic [AW-1:0]         fwd_a;
  logic [VALUE_BITS-1:0] fwd_d;

  sgcg_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  sgcg_addr #(.STORE_DEPTH(STORE_DEPTH)) u_addr (
    .clk, .start(state == S_A1 || (req.valid && req.ready)),
    .index_0(req.valid && req.ready ? req.payload.index_0 : cur.index_0),
    .index_1(req.valid && req.ready ? req.payload.index_1 : cur.index_1),
    .index_2(req.valid && req.ready ? req.payload.index_2 : cur.index_2),
    .stride_0, .stride_1, .stride_2,
    .all_corners(req.valid && req.ready ? req.payload.op[1] : cur.op[1]),
    .addr(caddr), .err(aerr)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.payload.corner_out = outv;
  assign rsp.payload.addr_error = oerr;

  function automatic logic signed [VALUE_BITS-1:0] clamp32(input logic [FB-1:0] x);
    logic signed [FB:0] s;
    s = {x[FB-1], x};
    if (s > (FB+1)'(signed'({1'b0, VMAX}))) return VMAX;
    if (s < (FB+1)'(signed'(VMIN)))         return VMIN;
    return VALUE_BITS'(s);
  endfunction

  logic [CB-1:0] ki;
  logic signed [VALUE_BITS-1:0] oldv, addend;
  logic signed [VALUE_BITS:0] sum;
  logic signed [VALUE_BITS-1:0] newv;
  logic [FB-1:0] rd32;

  always_comb begin
    ki     = k[CB-1:0];
    oldv   = (fwd_v && fwd_a == caddr[ki]) ? fwd_d : ram_rdata;
    addend = clamp32(cur.corner_in[ki*FB +: FB]);
    sum    = {oldv[VALUE_BITS-1], oldv} + {addend[VALUE_BITS-1], addend};
    if (sum[VALUE_BITS] != sum[VALUE_BITS-1]) newv = sum[VALUE_BITS] ? VMIN : VMAX;
    else newv = sum[VALUE_BITS-1:0];
    rd32 = FB'(unsigned'(oldv));
    if (VALUE_BITS < FB) rd32 = FB'(signed'(oldv));
  end

  // ram port use: clear, cell write, read issue, write back
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = caddr[ki];
    ram_wdata = newv;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1; ram_addr = clr_cnt[AW-1:0]; ram_wdata = '0;
      end
      S_A2: begin
        // cell write goes out as soon as the range check is known
        ram_addr = caddr[0];
        if (!aerr && cur.op == sgcg_pkg::OP_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = clamp32(cur.corner_in[0 +: FB]);
        end
      end
      S_RD: ram_addr = caddr[ki];
      S_MOD: begin
        ram_we = (cur.op == sgcg_pkg::OP_SCATTER);
        ram_addr = ram_we ? caddr[ki] : caddr[(CB)'(ki + 1'b1)];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; k <= '0; fwd_v <= 1'b0;
      stride_0 <= 12'd1; stride_1 <= 12'd16; stride_2 <= 12'd256;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sgcg_pkg::REG_STRIDE0: stride_0 <= cfg_data;
          sgcg_pkg::REG_STRIDE1: stride_1 <= cfg_data;
          sgcg_pkg::REG_STRIDE2: stride_2 <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(STORE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          cur <= req.payload; state <= S_A1;
        end
        S_A1: state <= S_A2;
        S_A2: begin
          outv <= '0; oerr <= aerr; k <= '0; fwd_v <= 1'b0;
          if (aerr) state <= S_OUT;
          else if (cur.op == sgcg_pkg::OP_WRITE) state <= S_IDLE;
          else state <= S_RD;
        end
        S_RD: state <= S_MOD;
        S_MOD: begin
          if (cur.op != sgcg_pkg::OP_WRITE) outv[ki] <= rd32;
          fwd_v <= (cur.op == sgcg_pkg::OP_SCATTER);
          fwd_a <= caddr[ki]; fwd_d <= newv;
          k <= k + 1'b1;
          if (cur.op == sgcg_pkg::OP_SCATTER) begin
            // write cycle used; read next corner in S_RD
            state <= (ki == CB'(NC - 1)) ? S_IDLE : S_RD;
          end else if (cur.op == sgcg_pkg::OP_READ || ki == CB'(NC - 1)) state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_req_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready) else $error("ready during clear");
  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && oerr) |-> !ram_we) else $error("write on error");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(oerr)) else $error("result lost");
endmodule
